[hw/rtl/i2c_eeprom_master_core_defines.svh]
// ----------------------------------------------------------------------------
// I2C EEPROM master assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_MASTER_CORE_DEFINES_SVH
`define I2C_EEPROM_MASTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define IEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c eeprom master: same-cycle check failed");

// Next-cycle implication.
`define IEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c eeprom master: next-cycle check failed");

`endif

[hw/rtl/iem_pkg.sv]
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Types, phase and stage codes and constants shared by the core modules.
// ----------------------------------------------------------------------------
package iem_pkg;

    localparam int MAX_LEN         = 256;
    localparam int STOP_HOLD_TICKS = 4;

    localparam int LEN_W  = 9;
    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;
    localparam int DEV_W  = 7;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Largest byte count that fits the length field, capped by MAX_LEN
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_LEN > 511) ? 9'd511 : LEN_W'(MAX_LEN);
    localparam logic [7:0] HOLD_TICKS = 8'(STOP_HOLD_TICKS);

    localparam logic [DEV_W-1:0]  DEVICE_SELECT_RST = 7'd80;
    localparam logic [BYTE_W-1:0] BYTE_GAP_RST      = 8'd30;

    typedef enum logic [0:0] {
        CFG_DEVICE_SELECT = 1'b0,
        CFG_BYTE_GAP      = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_TX    = 4'd2,
        PH_TXACK = 4'd3,
        PH_GAP   = 4'd4,
        PH_RX    = 4'd5,
        PH_RXACK = 4'd6,
        PH_STOP  = 4'd7,
        PH_HOLD  = 4'd8,
        PH_END   = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ST_CTRL_W = 3'd0,
        ST_ADDR_H = 3'd1,
        ST_ADDR_L = 3'd2,
        ST_DATA_W = 3'd3,
        ST_CTRL_R = 3'd4,
        ST_DATA_R = 3'd5
    } stage_t;

    typedef struct packed {
        logic [DEV_W-1:0]  device_select;
        logic [BYTE_W-1:0] byte_gap_ticks;
    } iem_cfg_t;

    typedef struct packed {
        logic              req_type;
        logic              is_read;
        logic [ADDR_W-1:0] mem_addr;
        logic [LEN_W-1:0]  xfer_len;
        logic [BYTE_W-1:0] wr_data;
        logic              sda_in;
    } iem_item_t;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_oe;
        logic [BYTE_W-1:0] rd_data;
        logic              rd_valid;
        logic              data_request;
        logic              busy_res;
        logic              done_res;
    } iem_result_t;

endpackage

[hw/rtl/i2c_eeprom_master_core.sv]
// ----------------------------------------------------------------------------
// I2C EEPROM master core
// Path: an accepted item goes through the input register, then the result
//   register, and leaves on m_tdata. Throughput: one item (tick or command)
//   per cycle while m_tready drains the result register, set by the
//   single-pass waveform step between the two registers.
// Reset: rst_n clears all control state; lines idle high and driven, registers
//   take device select 80 and byte gap 30.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_core
    import iem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // tdata, low bit up: is_read, mem_addr[15:0], xfer_len[8:0], wr_data[7:0],
    // sda_in, zero fill
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: req_type
    input  logic [0:0]           s_tuser,

    // tdata, low bit up: scl, sda_out, sda_oe, rd_data[7:0], rd_valid,
    // data_request, busy_res, done_res, zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic        in_valid_reg;
    iem_item_t   in_item_reg;
    logic        out_valid_reg;
    iem_result_t out_res_reg;
    logic        advance;
    iem_item_t   s_item;
    iem_cfg_t    cfg;
    iem_result_t step_res;

    // Unpack the slave transaction
    assign s_item.req_type = s_tuser[0];
    assign s_item.is_read  = s_tdata[0];
    assign s_item.mem_addr = s_tdata[16:1];
    assign s_item.xfer_len = s_tdata[25:17];
    assign s_item.wr_data  = s_tdata[33:26];
    assign s_item.sda_in   = s_tdata[34];

    // Move the held item into the result register whenever that slot is free
    // or being drained; the input register refills in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Payload holds without reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= s_item;
    end

    iem_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the bus waveform by one item when the held item moves on
    iem_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= step_res;
    end

    // Pack the master transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.data_request,
                       out_res_reg.rd_valid,
                       out_res_reg.rd_data,
                       out_res_reg.sda_oe,
                       out_res_reg.sda_out,
                       out_res_reg.scl};

endmodule

[hw/rtl/iem_cfg_regs.sv]
// ----------------------------------------------------------------------------
// I2C EEPROM master configuration registers
// Device select and byte gap registers behind a valid/ready write channel.
// ----------------------------------------------------------------------------
module iem_cfg_regs
    import iem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    output iem_cfg_t          cfg
);

    logic [DEV_W-1:0]  device_select_reg;
    logic [BYTE_W-1:0] byte_gap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_select_reg <= DEVICE_SELECT_RST;
            byte_gap_reg      <= BYTE_GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEVICE_SELECT: device_select_reg <= cfg_data[DEV_W-1:0];
                CFG_BYTE_GAP:      byte_gap_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.device_select  = device_select_reg;
    assign cfg.byte_gap_ticks = byte_gap_reg;

endmodule

[hw/rtl/iem_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C EEPROM master waveform sequencer
// Transfer state and one-item step logic for the bit-level bus waveform.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_master_core_defines.svh"

module iem_sequencer
    import iem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  iem_item_t   item,
    input  iem_cfg_t    cfg,
    output iem_result_t res
);

    phase_t            phase_reg, phase_next;
    stage_t            stage_reg, stage_next;
    logic [7:0]        sub_tick_reg, sub_tick_next;
    logic [3:0]        bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              read_mode_reg, read_mode_next;
    logic [BYTE_W-1:0] first_data_reg, first_data_next;
    logic              pending_reg, pending_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              oe_reg, oe_next;

    // what follows a finished byte
    phase_t            ab_phase;
    stage_t            ab_stage;
    logic [BYTE_W-1:0] ab_shift;
    logic [3:0]        ab_bit;
    logic [LEN_W-1:0]  ab_bytes;
    logic              ab_pending;
    logic              ab_req;
    logic [LEN_W-1:0]  bytes_dec;

    logic              take_ab;
    logic              rd_valid;
    logic              done;
    logic [LEN_W-1:0]  len_sat;
    logic [7:0]        sub_inc;
    logic [3:0]        bit_inc;
    logic [BYTE_W-1:0] ctrl_w;

    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;
    assign sub_inc   = sub_tick_reg + 8'd1;
    assign bit_inc   = bit_index_reg + 4'd1;
    assign ctrl_w    = {cfg.device_select, 1'b0};

    always_comb
    begin
        if (item.xfer_len == '0)
            len_sat = LEN_W'(1);
        else if (item.xfer_len > LEN_CAP)
            len_sat = LEN_CAP;
        else
            len_sat = item.xfer_len;
    end

    always_comb
    begin
        ab_phase   = PH_STOP;
        ab_stage   = stage_reg;
        ab_shift   = shift_reg;
        ab_bit     = bit_index_reg;
        ab_bytes   = bytes_left_reg;
        ab_pending = pending_reg;
        ab_req     = 1'b0;
        case (stage_reg)
            ST_CTRL_W:
            begin
                ab_phase = PH_TX;
                ab_stage = ST_ADDR_H;
                ab_shift = addr_reg[15:8];
                ab_bit   = '0;
            end
            ST_ADDR_H:
            begin
                ab_phase = PH_TX;
                ab_stage = ST_ADDR_L;
                ab_shift = addr_reg[7:0];
                ab_bit   = '0;
            end
            ST_ADDR_L:
            begin
                if (read_mode_reg)
                begin
                    ab_phase = PH_START;
                    ab_stage = ST_CTRL_R;
                end
                else
                begin
                    ab_phase = PH_TX;
                    ab_stage = ST_DATA_W;
                    ab_shift = first_data_reg;
                    ab_bit   = '0;
                end
            end
            ST_DATA_W:
            begin
                ab_bytes = bytes_dec;
                if (bytes_dec != '0)
                begin
                    ab_phase   = PH_TX;
                    ab_shift   = '0;
                    ab_bit     = '0;
                    ab_pending = 1'b1;
                    ab_req     = 1'b1;
                end
            end
            ST_CTRL_R:
            begin
                ab_phase = PH_RX;
                ab_stage = ST_DATA_R;
                ab_shift = '0;
                ab_bit   = '0;
            end
            default:
            begin
                ab_bytes = bytes_dec;
                if (bytes_dec != '0)
                begin
                    ab_phase = PH_RX;
                    ab_shift = '0;
                    ab_bit   = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        sub_tick_next   = sub_tick_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        addr_next       = addr_reg;
        read_mode_next  = read_mode_reg;
        first_data_next = first_data_reg;
        pending_next    = pending_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        oe_next         = oe_reg;
        take_ab         = 1'b0;
        rd_valid        = 1'b0;
        done            = 1'b0;

        if (item.req_type)
        begin
            // a command while busy is dropped
            if (phase_reg == PH_IDLE)
            begin
                bytes_left_next = len_sat;
                read_mode_next  = item.is_read;
                addr_next       = item.mem_addr;
                first_data_next = item.wr_data;
                pending_next    = 1'b0;
                stage_next      = ST_CTRL_W;
                sub_tick_next   = '0;
                bit_index_next  = '0;
                phase_next      = PH_START;
            end
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (sub_tick_reg == 8'd0)
                    begin
                        scl_next      = 1'b1;
                        sda_next      = 1'b1;
                        oe_next       = 1'b1;
                        sub_tick_next = 8'd1;
                    end
                    else
                    begin
                        sda_next       = 1'b0;
                        shift_next     = (stage_reg == ST_CTRL_R) ? (ctrl_w | 8'h01) : ctrl_w;
                        stage_next     = (stage_reg == ST_CTRL_R) ? ST_CTRL_R : ST_CTRL_W;
                        bit_index_next = '0;
                        sub_tick_next  = '0;
                        phase_next     = PH_TX;
                    end
                end
                PH_TX:
                begin
                    if (sub_tick_reg == 8'd0)
                    begin
                        if (pending_reg)
                        begin
                            shift_next   = item.wr_data;
                            pending_next = 1'b0;
                        end
                        oe_next       = 1'b1;
                        scl_next      = 1'b0;
                        sub_tick_next = 8'd1;
                    end
                    else if (sub_tick_reg == 8'd1)
                    begin
                        sda_next      = shift_reg[7];
                        shift_next    = {shift_reg[6:0], 1'b0};
                        sub_tick_next = 8'd2;
                    end
                    else
                    begin
                        scl_next       = 1'b1;
                        bit_index_next = bit_inc;
                        sub_tick_next  = '0;
                        if (bit_inc >= 4'd8)
                            phase_next = PH_TXACK;
                    end
                end
                PH_TXACK:
                begin
                    if (sub_tick_reg == 8'd0)
                    begin
                        scl_next      = 1'b0;
                        sub_tick_next = 8'd1;
                    end
                    else if (sub_tick_reg == 8'd1)
                    begin
                        sda_next      = 1'b0;
                        oe_next       = 1'b0;
                        sub_tick_next = 8'd2;
                    end
                    else if (sub_tick_reg == 8'd2)
                    begin
                        scl_next      = 1'b1;
                        sub_tick_next = 8'd3;
                    end
                    else
                    begin
                        oe_next  = 1'b1;
                        scl_next = 1'b0;
                        if (cfg.byte_gap_ticks == 8'd0)
                            take_ab = 1'b1;
                        else
                        begin
                            sub_tick_next = '0;
                            phase_next    = PH_GAP;
                        end
                    end
                end
                PH_GAP:
                begin
                    sub_tick_next = sub_inc;
                    if (sub_inc >= cfg.byte_gap_ticks)
                        take_ab = 1'b1;
                end
                PH_RX:
                begin
                    if (sub_tick_reg == 8'd0)
                    begin
                        oe_next       = 1'b0;
                        scl_next      = 1'b0;
                        sub_tick_next = 8'd1;
                    end
                    else if (sub_tick_reg == 8'd1)
                    begin
                        scl_next      = 1'b1;
                        sub_tick_next = 8'd2;
                    end
                    else
                    begin
                        shift_next     = {shift_reg[6:0], item.sda_in};
                        bit_index_next = bit_inc;
                        sub_tick_next  = '0;
                        if (bit_inc >= 4'd8)
                        begin
                            rd_valid   = 1'b1;
                            phase_next = PH_RXACK;
                        end
                    end
                end
                PH_RXACK:
                begin
                    if (sub_tick_reg == 8'd0)
                    begin
                        scl_next      = 1'b0;
                        sub_tick_next = 8'd1;
                    end
                    else if (sub_tick_reg == 8'd1)
                    begin
                        // NACK the last byte, ACK the others
                        sda_next      = (bytes_left_reg <= LEN_W'(1));
                        oe_next       = 1'b1;
                        sub_tick_next = 8'd2;
                    end
                    else if (sub_tick_reg == 8'd2)
                    begin
                        scl_next      = 1'b1;
                        sub_tick_next = 8'd3;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (cfg.byte_gap_ticks == 8'd0)
                            take_ab = 1'b1;
                        else
                        begin
                            sub_tick_next = '0;
                            phase_next    = PH_GAP;
                        end
                    end
                end
                PH_STOP:
                begin
                    sda_next      = 1'b0;
                    oe_next       = 1'b1;
                    sub_tick_next = '0;
                    phase_next    = PH_HOLD;
                end
                PH_HOLD:
                begin
                    scl_next      = 1'b1;
                    sub_tick_next = sub_inc;
                    if (sub_inc >= HOLD_TICKS)
                    begin
                        sub_tick_next = '0;
                        phase_next    = PH_END;
                    end
                end
                PH_END:
                begin
                    sda_next        = 1'b1;
                    done            = 1'b1;
                    sub_tick_next   = '0;
                    bit_index_next  = '0;
                    bytes_left_next = '0;
                    phase_next      = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (take_ab)
            begin
                phase_next      = ab_phase;
                stage_next      = ab_stage;
                shift_next      = ab_shift;
                bit_index_next  = ab_bit;
                sub_tick_next   = '0;
                bytes_left_next = ab_bytes;
                pending_next    = ab_pending;
            end
        end
    end

    assign res.scl          = scl_next;
    assign res.sda_out      = sda_next;
    assign res.sda_oe       = oe_next;
    assign res.rd_data      = rd_valid ? shift_next : '0;
    assign res.rd_valid     = rd_valid;
    assign res.data_request = take_ab & ab_req;
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.done_res     = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            stage_reg      <= ST_CTRL_W;
            sub_tick_reg   <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            bytes_left_reg <= '0;
            addr_reg       <= '0;
            read_mode_reg  <= 1'b0;
            first_data_reg <= '0;
            pending_reg    <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            sub_tick_reg   <= sub_tick_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            addr_reg       <= addr_next;
            read_mode_reg  <= read_mode_next;
            first_data_reg <= first_data_next;
            pending_reg    <= pending_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            oe_reg         <= oe_next;
        end
    end

    `IEM_ASSERT_NEXT(a_end_to_idle, step_en && !item.req_type && phase_reg == PH_END,
                     phase_reg == PH_IDLE && bytes_left_reg == '0)
    `IEM_ASSERT_NEXT(a_request_loads, step_en && res.data_request,
                     phase_reg == PH_TX && pending_reg && sub_tick_reg == 8'd0)
    `IEM_ASSERT_NEXT(a_read_byte_ack, step_en && res.rd_valid,
                     phase_reg == PH_RXACK && sub_tick_reg == 8'd0 && bit_index_reg == 4'd8)

endmodule
